// ===== sv/nec_ir_edge_decoder_unit_defines.svh =====
// Assertion macros for the NEC infrared edge decoder core.
`ifndef NEC_IR_EDGE_DECODER_UNIT_DEFINES_SVH
`define NEC_IR_EDGE_DECODER_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NECD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("necd assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define NECD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("necd assertion failed");

`endif

// ===== sv/necd_pkg.sv =====
// Types, codes, reset values and helper functions of the NEC infrared edge decoder.
package necd_pkg;

    // Bits gathered into one address or command byte.
    localparam int BITS_PER_BYTE_FIELD = 8;

    // Request operation codes.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BURST_WINDOW = 3'd0;
    localparam logic [2:0] CFG_GAP_WINDOW   = 3'd1;
    localparam logic [2:0] CFG_HOLD_WINDOW  = 3'd2;
    localparam logic [2:0] CFG_MARK_WINDOW  = 3'd3;
    localparam logic [2:0] CFG_ZERO_WINDOW  = 3'd4;
    localparam logic [2:0] CFG_ONE_WINDOW   = 3'd5;
    localparam logic [2:0] CFG_REPEAT_HOLD  = 3'd6;

    // Configuration reset values.
    localparam logic [15:0] BURST_WINDOW_RESET = 16'd38530;
    localparam logic [15:0] GAP_WINDOW_RESET   = 16'd19521;
    localparam logic [15:0] HOLD_WINDOW_RESET  = 16'd10270;
    localparam logic [15:0] MARK_WINDOW_RESET  = 16'd3078;
    localparam logic [15:0] ZERO_WINDOW_RESET  = 16'd3078;
    localparam logic [15:0] ONE_WINDOW_RESET   = 16'd7702;
    localparam logic [7:0]  REPEAT_HOLD_RESET  = 8'd7;

    // Reported phase codes.
    localparam logic [2:0] CODE_BURST    = 3'd0;
    localparam logic [2:0] CODE_GAP      = 3'd1;
    localparam logic [2:0] CODE_ADDR     = 3'd2;
    localparam logic [2:0] CODE_ADDR_INV = 3'd3;
    localparam logic [2:0] CODE_CMD      = 3'd4;
    localparam logic [2:0] CODE_CMD_INV  = 3'd5;
    localparam logic [2:0] CODE_REPEAT   = 3'd6;

    // Decoder phase, one-hot.
    typedef enum logic [6:0] {
        PH_BURST    = 7'b0000001,
        PH_GAP      = 7'b0000010,
        PH_ADDR     = 7'b0000100,
        PH_ADDR_INV = 7'b0001000,
        PH_CMD      = 7'b0010000,
        PH_CMD_INV  = 7'b0100000,
        PH_REPEAT   = 7'b1000000
    } phase_t;

    // Timing windows and hold count from the configuration registers.
    typedef struct packed {
        logic [15:0] burst_window;
        logic [15:0] gap_window;
        logic [15:0] hold_window;
        logic [15:0] mark_window;
        logic [15:0] zero_window;
        logic [15:0] one_window;
        logic [7:0]  repeat_hold_wraps;
    } necd_cfg_t;

    // One result as it leaves the decoder core.
    typedef struct packed {
        logic [2:0] decoder_phase;
        logic       repeat_active;
        logic       frame_ready;
        logic [7:0] frame_command;
        logic [7:0] frame_address;
    } necd_result_t;

    // A time fits a window when it lies strictly between the low and high bytes.
    function automatic logic in_window(input logic [15:0] win, input logic [7:0] t);
        return (t > win[7:0]) && (t < win[15:8]);
    endfunction

    // Maps the one-hot phase to its reported code.
    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_BURST:    code = CODE_BURST;
            PH_GAP:      code = CODE_GAP;
            PH_ADDR:     code = CODE_ADDR;
            PH_ADDR_INV: code = CODE_ADDR_INV;
            PH_CMD:      code = CODE_CMD;
            PH_CMD_INV:  code = CODE_CMD_INV;
            PH_REPEAT:   code = CODE_REPEAT;
            default:     code = CODE_BURST;
        endcase
        return code;
    endfunction

    // Phase that follows a completed data byte.
    function automatic phase_t next_data_phase(input phase_t ph);
        phase_t nxt;
        unique case (ph)
            PH_ADDR:     nxt = PH_ADDR_INV;
            PH_ADDR_INV: nxt = PH_CMD;
            PH_CMD:      nxt = PH_CMD_INV;
            default:     nxt = PH_BURST;
        endcase
        return nxt;
    endfunction

endpackage

// ===== sv/nec_ir_edge_decoder_unit.sv =====
// A request accepted into the input register is stepped through the decoder state update
// into the result register when that register is free or being drained.
// Throughput: one request per cycle unless the result stalls; the input register, the
// decoder state update and the result register run in a single pass, so requests flow
// back to back. A stalled result holds while one more request waits in the input register.
// Reset (rst_n low, asynchronous) clears the decoder state and both stages and
// loads the timing windows and repeat hold with their default values.
module nec_ir_edge_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] pin_level, [7:1] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] frame_address, [15:8] frame_command,
                                   // [16] frame_ready, [17] repeat_active,
                                   // [20:18] decoder_phase, [23:21] zero
    // Configuration writes.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic                   in_valid_reg;
    logic [1:0]             op_reg;
    logic                   pin_reg;
    logic                   out_valid_reg;
    necd_pkg::necd_result_t out_data_reg;
    necd_pkg::necd_cfg_t    cfg;
    necd_pkg::necd_result_t result;
    logic                   advance;
    logic                   s_accept;

    // A request moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    necd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    necd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .op        (op_reg),
        .pin_level (pin_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= s_accept || (in_valid_reg && !advance);
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg  <= s_tuser;
            pin_reg <= s_tdata[0];
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

endmodule

// ===== sv/necd_cfg.sv =====
// Configuration register file of the NEC infrared edge decoder.
module necd_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output necd_pkg::necd_cfg_t cfg
);

    necd_pkg::necd_cfg_t cfg_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.burst_window      <= necd_pkg::BURST_WINDOW_RESET;
            cfg_reg.gap_window        <= necd_pkg::GAP_WINDOW_RESET;
            cfg_reg.hold_window       <= necd_pkg::HOLD_WINDOW_RESET;
            cfg_reg.mark_window       <= necd_pkg::MARK_WINDOW_RESET;
            cfg_reg.zero_window       <= necd_pkg::ZERO_WINDOW_RESET;
            cfg_reg.one_window        <= necd_pkg::ONE_WINDOW_RESET;
            cfg_reg.repeat_hold_wraps <= necd_pkg::REPEAT_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                necd_pkg::CFG_BURST_WINDOW: cfg_reg.burst_window      <= cfg_data;
                necd_pkg::CFG_GAP_WINDOW:   cfg_reg.gap_window        <= cfg_data;
                necd_pkg::CFG_HOLD_WINDOW:  cfg_reg.hold_window       <= cfg_data;
                necd_pkg::CFG_MARK_WINDOW:  cfg_reg.mark_window       <= cfg_data;
                necd_pkg::CFG_ZERO_WINDOW:  cfg_reg.zero_window       <= cfg_data;
                necd_pkg::CFG_ONE_WINDOW:   cfg_reg.one_window        <= cfg_data;
                necd_pkg::CFG_REPEAT_HOLD:  cfg_reg.repeat_hold_wraps <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/necd_core.sv =====
// Decoder state and its combinational update for one request.
`include "nec_ir_edge_decoder_unit_defines.svh"

module necd_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  logic [1:0]             op,
    input  logic                   pin_level,
    input  necd_pkg::necd_cfg_t    cfg,
    output necd_pkg::necd_result_t result
);

    necd_pkg::phase_t phase_reg, phase_next;
    logic [7:0] timer_reg, timer_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] addr_hold_reg, addr_hold_next;
    logic [7:0] cmd_hold_reg, cmd_hold_next;
    logic [7:0] pub_addr_reg, pub_addr_next;
    logic [7:0] pub_cmd_reg, pub_cmd_next;
    logic       ready_reg, ready_next;
    logic       repeat_reg, repeat_next;
    logic [7:0] hold_cnt_reg, hold_cnt_next;

    // Window checks on the time since the last edge.
    logic       in_burst, in_gap, in_hold, in_mark, in_zero, in_one;
    logic       gather;
    logic [2:0] bit_sel;
    logic       ref_bit;

    assign in_burst = necd_pkg::in_window(cfg.burst_window, timer_reg);
    assign in_gap   = necd_pkg::in_window(cfg.gap_window, timer_reg);
    assign in_hold  = necd_pkg::in_window(cfg.hold_window, timer_reg);
    assign in_mark  = necd_pkg::in_window(cfg.mark_window, timer_reg);
    assign in_zero  = necd_pkg::in_window(cfg.zero_window, timer_reg);
    assign in_one   = necd_pkg::in_window(cfg.one_window, timer_reg);
    assign gather   = (phase_reg == necd_pkg::PH_ADDR) || (phase_reg == necd_pkg::PH_CMD);
    assign bit_sel  = bit_reg[2:0];
    assign ref_bit  = (phase_reg == necd_pkg::PH_ADDR_INV) ? addr_hold_reg[bit_sel]
                                                           : cmd_hold_reg[bit_sel];

    // Next state for the request being processed.
    always_comb
    begin
        logic       bit_ok;
        logic       bit_add;
        logic [3:0] count;

        phase_next     = phase_reg;
        timer_next     = timer_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        addr_hold_next = addr_hold_reg;
        cmd_hold_next  = cmd_hold_reg;
        pub_addr_next  = pub_addr_reg;
        pub_cmd_next   = pub_cmd_reg;
        ready_next     = ready_reg;
        repeat_next    = repeat_reg;
        hold_cnt_next  = hold_cnt_reg;
        bit_ok         = 1'b1;
        bit_add        = 1'b0;
        count          = bit_reg;

        if (step_en)
        begin
            unique case (op)
                necd_pkg::OP_TICK:
                begin
                    timer_next = timer_reg + 8'd1;
                    // Timer wrap counts down the repeat hold.
                    if (timer_reg == 8'hFF)
                    begin
                        if (hold_cnt_reg != 8'd0)
                        begin
                            hold_cnt_next = hold_cnt_reg - 8'd1;
                        end
                        if (hold_cnt_reg <= 8'd1)
                        begin
                            repeat_next = 1'b0;
                        end
                    end
                end
                necd_pkg::OP_EDGE:
                begin
                    timer_next = 8'd0;
                    unique case (phase_reg)
                        necd_pkg::PH_BURST:
                        begin
                            phase_next = (pin_level && in_burst) ? necd_pkg::PH_GAP
                                                                 : necd_pkg::PH_BURST;
                        end
                        necd_pkg::PH_GAP:
                        begin
                            if (!pin_level && in_gap)
                            begin
                                phase_next = necd_pkg::PH_ADDR;
                            end
                            else if (!pin_level && in_hold)
                            begin
                                phase_next = necd_pkg::PH_REPEAT;
                            end
                            else
                            begin
                                phase_next = necd_pkg::PH_BURST;
                            end
                        end
                        necd_pkg::PH_ADDR, necd_pkg::PH_ADDR_INV,
                        necd_pkg::PH_CMD, necd_pkg::PH_CMD_INV:
                        begin
                            if (pin_level)
                            begin
                                // A mark only has to fit its window.
                                phase_next = in_mark ? phase_reg : necd_pkg::PH_BURST;
                            end
                            else
                            begin
                                // A space carries one bit; inverted bytes are compared.
                                if (in_zero)
                                begin
                                    bit_add = 1'b1;
                                    if (gather)
                                    begin
                                        shift_next[bit_sel] = 1'b0;
                                    end
                                    else if (!ref_bit)
                                    begin
                                        bit_ok = 1'b0;
                                    end
                                end
                                else if (in_one)
                                begin
                                    bit_add = 1'b1;
                                    if (gather)
                                    begin
                                        shift_next[bit_sel] = 1'b1;
                                    end
                                    else if (ref_bit)
                                    begin
                                        bit_ok = 1'b0;
                                    end
                                end

                                if (!bit_ok)
                                begin
                                    phase_next = necd_pkg::PH_BURST;
                                end
                                else
                                begin
                                    count = bit_add ? bit_reg + 4'd1 : bit_reg;
                                    if (count >= 4'(necd_pkg::BITS_PER_BYTE_FIELD))
                                    begin
                                        bit_next = 4'd0;
                                        if (phase_reg == necd_pkg::PH_ADDR)
                                        begin
                                            addr_hold_next = shift_next;
                                        end
                                        else if (phase_reg == necd_pkg::PH_CMD)
                                        begin
                                            cmd_hold_next = shift_next;
                                        end
                                        // A checked frame is published unless one waits.
                                        if (phase_reg == necd_pkg::PH_CMD_INV && !ready_reg)
                                        begin
                                            pub_addr_next = addr_hold_reg;
                                            pub_cmd_next  = cmd_hold_reg;
                                            ready_next    = 1'b1;
                                        end
                                        phase_next = necd_pkg::next_data_phase(phase_reg);
                                    end
                                    else
                                    begin
                                        bit_next = count;
                                    end
                                end
                            end
                        end
                        necd_pkg::PH_REPEAT:
                        begin
                            repeat_next   = 1'b1;
                            hold_cnt_next = cfg.repeat_hold_wraps;
                            phase_next    = necd_pkg::PH_BURST;
                        end
                        default:
                        begin
                            phase_next = necd_pkg::PH_BURST;
                        end
                    endcase
                    // Every return to burst restarts the bit count.
                    if (phase_next == necd_pkg::PH_BURST)
                    begin
                        bit_next = 4'd0;
                    end
                end
                necd_pkg::OP_ACK:
                begin
                    ready_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= necd_pkg::PH_BURST;
            timer_reg     <= 8'd0;
            bit_reg       <= 4'd0;
            shift_reg     <= 8'd0;
            addr_hold_reg <= 8'd0;
            cmd_hold_reg  <= 8'd0;
            pub_addr_reg  <= 8'd0;
            pub_cmd_reg   <= 8'd0;
            ready_reg     <= 1'b0;
            repeat_reg    <= 1'b0;
            hold_cnt_reg  <= 8'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            addr_hold_reg <= addr_hold_next;
            cmd_hold_reg  <= cmd_hold_next;
            pub_addr_reg  <= pub_addr_next;
            pub_cmd_reg   <= pub_cmd_next;
            ready_reg     <= ready_next;
            repeat_reg    <= repeat_next;
            hold_cnt_reg  <= hold_cnt_next;
        end
    end

    // The result reflects the state after this request.
    assign result.frame_address = pub_addr_next;
    assign result.frame_command = pub_cmd_next;
    assign result.frame_ready   = ready_next;
    assign result.repeat_active = repeat_next;
    assign result.decoder_phase = necd_pkg::phase_code(phase_next);

    // A ready flag only rises at the end of the inverted command byte.
    `NECD_ASSERT_SAME(a_ready_from_frame, clk, rst_n, ready_reg && !$past(ready_reg),
        $past(phase_reg) == necd_pkg::PH_CMD_INV)
    // The repeat flag only rises on the edge that closes a repeat code.
    `NECD_ASSERT_SAME(a_repeat_from_code, clk, rst_n, $rose(repeat_reg),
        $past(phase_reg) == necd_pkg::PH_REPEAT)
    // Published bytes change only together with a new ready flag.
    `NECD_ASSERT_SAME(a_publish_sets_ready, clk, rst_n,
        pub_addr_reg != $past(pub_addr_reg) || pub_cmd_reg != $past(pub_cmd_reg),
        ready_reg && !$past(ready_reg))
    // A data byte never holds a full count between requests.
    `NECD_ASSERT_SAME(a_bit_count_bound, clk, rst_n, 1'b1,
        bit_reg < 4'(necd_pkg::BITS_PER_BYTE_FIELD))
    // Without a request the state stays put.
    `NECD_ASSERT_NEXT(a_idle_holds, clk, rst_n, !step_en,
        $stable(phase_reg) && $stable(timer_reg) && $stable(ready_reg))

endmodule

// ===== sim/nec_ir_edge_decoder_unit_test.sv =====
// Self-checking testbench for the NEC infrared edge decoder unit, with a built-in decoder model.
module nec_ir_edge_decoder_unit_test;
    import necd_pkg::*;

    // Operation code that the decoder leaves without effect.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // One request as it travels on the input stream.
    typedef struct packed {
        logic [1:0] op;
        logic       pin;
    } ir_request_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    ir_request_t  ir_requests[$];
    necd_result_t predicted_status[$];
    int           queued_count = 0;
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         req_taken = 1'b0;

    // Window settings and decoder state as the model sees them.
    logic [15:0] burst_win, gap_win, hold_win, mark_win, zero_win, one_win;
    logic [7:0]  hold_reload;
    logic [2:0]  ir_phase;
    logic [7:0]  tick_count;
    logic [3:0]  bit_count;
    logic [7:0]  gather_byte, address_byte, command_byte;
    logic [7:0]  shown_address, shown_command, hold_count;
    logic        ready_bit, repeat_bit;

    nec_ir_edge_decoder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A time fits when it lies strictly between the low and the high byte.
    function automatic logic time_fits(input logic [15:0] win, input int t);
        int lo_t;
        int hi_t;
        lo_t = win[7:0];
        hi_t = win[15:8];
        return (lo_t < t) && (t < hi_t);
    endfunction

    // Edge seen in one of the four byte phases; returns the next phase.
    task automatic data_edge(input logic pin, input logic [7:0] t, output logic [2:0] nxt);
        logic       gather;
        logic       bad;
        logic [7:0] mask;
        logic [7:0] true_byte;
        gather = (ir_phase == CODE_ADDR) || (ir_phase == CODE_CMD);
        mask = 8'd1 << bit_count[2:0];
        true_byte = (ir_phase == CODE_ADDR_INV) ? address_byte : command_byte;
        bad = 1'b0;
        nxt = ir_phase;
        if (pin)
        begin
            if (!time_fits(mark_win, t))
                nxt = CODE_BURST;
        end
        else
        begin
            if (time_fits(zero_win, t))
            begin
                if (gather)
                    gather_byte = gather_byte & ~mask;
                else if ((true_byte & mask) == 8'd0)
                    bad = 1'b1;
                if (!bad)
                    bit_count = bit_count + 4'd1;
            end
            else if (time_fits(one_win, t))
            begin
                if (gather)
                    gather_byte = gather_byte | mask;
                else if ((true_byte & mask) != 8'd0)
                    bad = 1'b1;
                if (!bad)
                    bit_count = bit_count + 4'd1;
            end
            if (bad)
                nxt = CODE_BURST;
            else if (bit_count >= 4'd8)
            begin
                bit_count = 4'd0;
                case (ir_phase)
                    CODE_ADDR:
                    begin
                        address_byte = gather_byte;
                        nxt = CODE_ADDR_INV;
                    end
                    CODE_ADDR_INV: nxt = CODE_CMD;
                    CODE_CMD:
                    begin
                        command_byte = gather_byte;
                        nxt = CODE_CMD_INV;
                    end
                    default:
                    begin
                        // A finished frame is dropped while the last one is unread.
                        if (!ready_bit)
                        begin
                            shown_address = address_byte;
                            shown_command = command_byte;
                            ready_bit = 1'b1;
                        end
                        nxt = CODE_BURST;
                    end
                endcase
            end
        end
    endtask

    // Applies one request to the model and returns the status that follows it.
    task automatic decode_request(input logic [1:0] op, input logic pin,
                                  output necd_result_t status);
        logic [7:0] t;
        logic [2:0] nxt;
        case (op)
            OP_TICK:
            begin
                tick_count = tick_count + 8'd1;
                if (tick_count == 8'd0)
                begin
                    if (hold_count != 8'd0)
                        hold_count = hold_count - 8'd1;
                    if (hold_count == 8'd0)
                        repeat_bit = 1'b0;
                end
            end
            OP_EDGE:
            begin
                t = tick_count;
                tick_count = 8'd0;
                case (ir_phase)
                    CODE_BURST:
                        nxt = (pin && time_fits(burst_win, t)) ? CODE_GAP : CODE_BURST;
                    CODE_GAP:
                    begin
                        if (!pin && time_fits(gap_win, t))
                            nxt = CODE_ADDR;
                        else if (!pin && time_fits(hold_win, t))
                            nxt = CODE_REPEAT;
                        else
                            nxt = CODE_BURST;
                    end
                    CODE_ADDR, CODE_ADDR_INV, CODE_CMD, CODE_CMD_INV:
                        data_edge(pin, t, nxt);
                    default:
                    begin
                        // Any edge after a repeat code holds the key.
                        repeat_bit = 1'b1;
                        hold_count = hold_reload;
                        nxt = CODE_BURST;
                    end
                endcase
                if (nxt == CODE_BURST)
                    bit_count = 4'd0;
                ir_phase = nxt;
            end
            OP_ACK: ready_bit = 1'b0;
            default: ;
        endcase
        status.frame_address = shown_address;
        status.frame_command = shown_command;
        status.frame_ready   = ready_bit;
        status.repeat_active = repeat_bit;
        status.decoder_phase = ir_phase;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d, at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Feeds requests from the queue and drives the result ready.
    always @(negedge clk)
    begin : request_driver
        ir_request_t next_req;
        if (!s_tvalid || req_taken)
        begin
            if (ir_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = ir_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_req.op;
                s_tdata  <= {7'd0, next_req.pin};
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Predicts on each accepted request and checks each accepted result.
    always @(posedge clk)
    begin : status_monitor
        necd_result_t predicted;
        necd_result_t got;
        necd_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decode_request(s_tuser, s_tdata[0], predicted);
                predicted_status.push_back(predicted);
            end
            if (m_tvalid && m_tready)
            begin
                got = necd_result_t'(m_tdata[20:0]);
                if (predicted_status.size() == 0)
                    report_mismatch("result with none pending", got, 0);
                else
                begin
                    want = predicted_status.pop_front();
                    if (got.frame_address != want.frame_address)
                        report_mismatch("frame_address", got.frame_address, want.frame_address);
                    if (got.frame_command != want.frame_command)
                        report_mismatch("frame_command", got.frame_command, want.frame_command);
                    if (got.frame_ready != want.frame_ready)
                        report_mismatch("frame_ready", got.frame_ready, want.frame_ready);
                    if (got.repeat_active != want.repeat_active)
                        report_mismatch("repeat_active", got.repeat_active, want.repeat_active);
                    if (got.decoder_phase != want.decoder_phase)
                        report_mismatch("decoder_phase", got.decoder_phase, want.decoder_phase);
                end
            end
        end
        req_taken = rst_n && s_tvalid && s_tready;
    end

    task automatic queue_request(input logic [1:0] op, input logic pin);
        ir_request_t req;
        req.op  = op;
        req.pin = pin;
        ir_requests.push_back(req);
        queued_count++;
    endtask

    // A run of ticks followed by one edge.
    task automatic push_span(input int ticks, input logic pin);
        repeat (ticks)
            queue_request(OP_TICK, 1'($urandom));
        queue_request(OP_EDGE, pin);
    endtask

    // A time inside the window, kept short, and outside the avoided window if possible.
    function automatic int pick_fit(input logic [15:0] win, input logic [15:0] avoid);
        int lo_t;
        int hi_t;
        int top;
        int t;
        int tries;
        lo_t = win[7:0];
        hi_t = win[15:8];
        if (hi_t - lo_t < 2)
            return $urandom_range(6);
        top = (hi_t - 1 < lo_t + 8) ? hi_t - 1 : lo_t + 8;
        t = lo_t + 1;
        for (tries = 0; tries < 8; tries++)
        begin
            case ($urandom_range(3))
                0: t = lo_t + 1;
                1: t = (hi_t - 1 <= lo_t + 40) ? hi_t - 1 : top;
                default: t = $urandom_range(top, lo_t + 1);
            endcase
            if (!time_fits(avoid, t))
                break;
        end
        return t;
    endfunction

    // A time just outside the window, or zero.
    function automatic int pick_miss(input logic [15:0] win);
        int t;
        case ($urandom_range(2))
            0: t = 0;
            1: t = (win[7:0] <= 40) ? win[7:0] : 0;
            default: t = (win[15:8] <= 40) ? win[15:8] : 0;
        endcase
        return t;
    endfunction

    // A space that counts as neither a zero nor a one.
    function automatic int pick_neither();
        int t;
        int tries;
        for (tries = 0; tries < 8; tries++)
        begin
            t = $urandom_range(12);
            if (!time_fits(zero_win, t) && !time_fits(one_win, t))
                return t;
        end
        return 0;
    endfunction

    // Leading burst, start gap and 32 bits; a flawed frame may have timing and data errors.
    task automatic push_frame(input bit flawed);
        logic [7:0]  addr_val;
        logic [7:0]  cmd_val;
        logic [31:0] frame_bits;
        logic        bit_val;
        int          j;
        addr_val = 8'($urandom);
        cmd_val = 8'($urandom);
        frame_bits = {~cmd_val, cmd_val, ~addr_val, addr_val};
        push_span((flawed && $urandom_range(9) == 0) ? pick_miss(burst_win)
                                                      : pick_fit(burst_win, 16'h0000), 1'b1);
        push_span(pick_fit(gap_win, 16'h0000), 1'b0);
        for (j = 0; j < 32; j++)
        begin
            bit_val = frame_bits[j];
            if (flawed && $urandom_range(23) == 0)
                bit_val = ~bit_val;
            if (flawed && $urandom_range(9) == 0)
            begin
                push_span(pick_fit(mark_win, 16'h0000), 1'b1);
                push_span(pick_neither(), 1'b0);
            end
            push_span((flawed && $urandom_range(29) == 0) ? pick_miss(mark_win)
                                                           : pick_fit(mark_win, 16'h0000), 1'b1);
            push_span(bit_val ? pick_fit(one_win, zero_win) : pick_fit(zero_win, 16'h0000),
                      1'b0);
        end
    endtask

    // Leading burst, short gap, then an edge of either level.
    task automatic push_repeat();
        push_span(pick_fit(burst_win, 16'h0000), 1'b1);
        push_span(pick_fit(hold_win, gap_win), 1'b0);
        push_span($urandom_range(4), 1'($urandom));
    endtask

    task automatic push_random(input int count);
        int stop_at;
        int roll;
        stop_at = queued_count + count;
        while (queued_count < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                push_frame(1'b0);
            else if (roll < 55)
                push_frame(1'b1);
            else if (roll < 70)
                push_repeat();
            else if (roll < 82)
                queue_request(OP_ACK, 1'($urandom));
            else
                repeat ($urandom_range(6, 1))
                    queue_request(2'($urandom), 1'($urandom));
        end
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            CFG_BURST_WINDOW: burst_win = value;
            CFG_GAP_WINDOW:   gap_win = value;
            CFG_HOLD_WINDOW:  hold_win = value;
            CFG_MARK_WINDOW:  mark_win = value;
            CFG_ZERO_WINDOW:  zero_win = value;
            CFG_ONE_WINDOW:   one_win = value;
            CFG_REPEAT_HOLD:  hold_reload = value[7:0];
            default: ;
        endcase
    endtask

    task automatic load_windows(input logic [15:0] burst_v, input logic [15:0] gap_v,
                                input logic [15:0] hold_v, input logic [15:0] mark_v,
                                input logic [15:0] zero_v, input logic [15:0] one_v,
                                input logic [7:0] wraps);
        write_register(CFG_BURST_WINDOW, burst_v);
        write_register(CFG_GAP_WINDOW, gap_v);
        write_register(CFG_HOLD_WINDOW, hold_v);
        write_register(CFG_MARK_WINDOW, mark_v);
        write_register(CFG_ZERO_WINDOW, zero_v);
        write_register(CFG_ONE_WINDOW, one_v);
        write_register(CFG_REPEAT_HOLD, {8'($urandom), wraps});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both.
    task automatic set_idling(input int mode);
        case (mode)
            1:
            begin
                send_idle_pct = 49;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 49;
            end
            3:
            begin
                send_idle_pct = 18;
                recv_stall_pct = 18;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic wait_drained();
        while (ir_requests.size() != 0 || s_tvalid || predicted_status.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Reset, then one phase per window setting, with the tight windows used twice.
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tuser = OP_TICK;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BURST_WINDOW;
        cfg_data = 16'd0;
        burst_win = BURST_WINDOW_RESET;
        gap_win = GAP_WINDOW_RESET;
        hold_win = HOLD_WINDOW_RESET;
        mark_win = MARK_WINDOW_RESET;
        zero_win = ZERO_WINDOW_RESET;
        one_win = ONE_WINDOW_RESET;
        hold_reload = REPEAT_HOLD_RESET;
        ir_phase = CODE_BURST;
        tick_count = 8'd0;
        bit_count = 4'd0;
        gather_byte = 8'd0;
        address_byte = 8'd0;
        command_byte = 8'd0;
        shown_address = 8'd0;
        shown_command = 8'd0;
        hold_count = 8'd0;
        ready_bit = 1'b0;
        repeat_bit = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default windows: a repeat code, then a frame start with one zero and one one bit.
        set_idling(0);
        push_span(140, 1'b1);
        push_span(35, 1'b0);
        push_span(0, 1'b1);
        push_span(131, 1'b1);
        push_span(75, 1'b0);
        push_span(7, 1'b1);
        push_span(11, 1'b0);
        push_span(11, 1'b1);
        push_span(23, 1'b0);
        push_span(12, 1'b1);
        wait_drained();

        // Tight windows: burst 2..3, gap 2, hold 3..4, mark 1, zero 1, one 2.
        load_windows({8'd4, 8'd1}, {8'd3, 8'd1}, {8'd5, 8'd2}, {8'd2, 8'd0},
                     {8'd2, 8'd0}, {8'd3, 8'd1}, 8'd1);
        set_idling(1);
        // Unused op code and acknowledge with nothing ready.
        queue_request(OP_SPARE, 1'b1);
        queue_request(OP_SPARE, 1'b0);
        queue_request(OP_ACK, 1'b1);
        // Edges with no time, then burst at the exclusive bounds.
        push_span(0, 1'b1);
        push_span(0, 1'b0);
        push_span(1, 1'b1);
        push_span(4, 1'b1);
        // Burst, then a rising pin where the gap should fall.
        push_span(3, 1'b1);
        push_span(2, 1'b1);
        // Burst, short gap, falling edge: key repeat.
        push_span(2, 1'b1);
        push_span(3, 1'b0);
        push_span(0, 1'b0);
        push_random(200);
        // Repeat code with a hold of one wrap, released as the timer wraps.
        push_repeat();
        push_span(256 + $urandom_range(8), 1'b1);
        wait_drained();

        // Overlapping windows: gap wins over hold, zero wins over one.
        load_windows({8'd6, 8'd2}, {8'd6, 8'd2}, {8'd8, 8'd3}, {8'd4, 8'd1},
                     {8'd4, 8'd1}, {8'd7, 8'd2}, 8'd2);
        set_idling(2);
        push_random(180);
        wait_drained();

        // Widest windows and a zero hold count.
        load_windows(16'hFF00, 16'hFF05, 16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00, 8'd0);
        set_idling(3);
        push_random(90);
        push_repeat();
        push_span(256 + $urandom_range(8), 1'b0);
        wait_drained();

        // Empty windows: nothing can fit.
        load_windows(16'h0000, 16'hFFFF, 16'h00FF, 16'h0000, 16'hFFFF, 16'h0101, 8'hFF);
        set_idling(0);
        push_random(40);
        wait_drained();

        // Tight windows again under mixed idling.
        load_windows({8'd4, 8'd1}, {8'd3, 8'd1}, {8'd5, 8'd2}, {8'd2, 8'd0},
                     {8'd2, 8'd0}, {8'd3, 8'd1}, 8'd1);
        set_idling(3);
        push_random(120);
        wait_drained();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog for a run that stops making progress.
    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule
